FILE: design/toy_cpu_instruction_step_top_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the toy CPU instruction step block
// Shared property wrappers; each use reports through $error.
// ----------------------------------------------------------------------------
`ifndef TOY_CPU_INSTRUCTION_STEP_TOP_MACROS_SVH
`define TOY_CPU_INSTRUCTION_STEP_TOP_MACROS_SVH

// Same-cycle implication, disabled during reset
`define TCIS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Next-cycle implication, disabled during reset
`define TCIS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

FILE: design/tcis_pkg.sv
// ----------------------------------------------------------------------------
// tcis_pkg
// Opcodes, selectors and sizes of the toy CPU instruction step block.
// ----------------------------------------------------------------------------
package tcis_pkg;

  localparam int unsigned PC_W        = 11;
  localparam int unsigned WORD_W      = 16;
  localparam int unsigned NUM_REGS    = 4;
  localparam int unsigned MEM_WORDS   = 256;
  localparam int unsigned MEM_AW      = $clog2(MEM_WORDS);
  localparam int unsigned COLOR_W     = 4;

  // Counter at or beyond this value means halted
  localparam logic [PC_W-1:0] PROGRAM_SIZE = 11'd1024;
  // Highest counter value a step can produce
  localparam logic [PC_W-1:0] PC_MAX       = 11'd1026;

  // Opcodes
  localparam logic [7:0] OP_NOP     = 8'h00;
  localparam logic [7:0] OP_ADD     = 8'h01;
  localparam logic [7:0] OP_SUB     = 8'h02;
  localparam logic [7:0] OP_MUL     = 8'h03;
  localparam logic [7:0] OP_LDI_R1  = 8'h04;
  localparam logic [7:0] OP_LDI_R2  = 8'h05;
  localparam logic [7:0] OP_MOV     = 8'h06;
  localparam logic [7:0] OP_CMP     = 8'h07;
  localparam logic [7:0] OP_MEMMOV  = 8'h08;
  localparam logic [7:0] OP_JEQ     = 8'h09;
  localparam logic [7:0] OP_JZ      = 8'h0A;
  localparam logic [7:0] OP_JC      = 8'h0B;
  localparam logic [7:0] OP_JO      = 8'h0C;
  localparam logic [7:0] OP_PIXEL   = 8'h0D;
  localparam logic [7:0] OP_STORE   = 8'h0E;
  localparam logic [7:0] OP_LOAD    = 8'h0F;

  // Register move selectors
  localparam logic [7:0] MOV_R1_TO_R2 = 8'd0;
  localparam logic [7:0] MOV_R2_TO_R3 = 8'd1;
  localparam logic [7:0] MOV_R3_TO_R4 = 8'd2;
  localparam logic [7:0] MOV_R4_TO_R1 = 8'd3;

  // Data memory words that hold the pixel colour
  localparam logic [MEM_AW-1:0] ADDR_RED   = 8'd0;
  localparam logic [MEM_AW-1:0] ADDR_GREEN = 8'd1;
  localparam logic [MEM_AW-1:0] ADDR_BLUE  = 8'd2;

  // Instruction lengths
  localparam logic [PC_W-1:0] LEN_1 = 11'd1;
  localparam logic [PC_W-1:0] LEN_2 = 11'd2;
  localparam logic [PC_W-1:0] LEN_3 = 11'd3;

  typedef logic [WORD_W-1:0] word_t;

endpackage

FILE: design/toy_cpu_instruction_step_top.sv
// ----------------------------------------------------------------------------
// toy_cpu_instruction_step_top
// Executes one fetched instruction of a 16-opcode toy processor per transaction.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries the opcode byte and the two
//   operand bytes that follow it. Output channel (out_valid / out_stall)
//   returns one result per input: next program counter, an optional pixel
//   store, bad-opcode and halted flags, and register one after the step.
//   The edge that takes an instruction loads the input register and also
//   reads the data memory at its address; execute then writes the step
//   into the result register, which drives out_valid.
//   Throughput is one instruction per cycle while out_stall is low; the single
//   data memory read port and the register/flag update of the execute cycle set
//   that figure, with a write of the instruction ahead forwarded into the read.
//   While out_stall holds a waiting result, one more instruction is taken into
//   the input register; in_stall rises after that.
//   Reset clears registers, flags, program counter, colour words and the
//   valid bit of every data memory word (an unwritten word reads as zero), so
//   the block takes input in the first cycle after reset.
//   Once the counter reaches the program size every step reports halted and
//   changes nothing.
// ----------------------------------------------------------------------------
`include "toy_cpu_instruction_step_top_macros.svh"

module toy_cpu_instruction_step_top
  import tcis_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [7:0]                in_opcode,
  input  logic [7:0]                in_operand_a,
  input  logic [7:0]                in_operand_b,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [PC_W-1:0]           out_next_pc,
  output logic                      out_pixel_write,
  output logic [7:0]                out_pixel_slot,
  output logic [7:0]                out_pixel_x,
  output logic [7:0]                out_pixel_y,
  output logic [COLOR_W-1:0]        out_red,
  output logic [COLOR_W-1:0]        out_green,
  output logic [COLOR_W-1:0]        out_blue,
  output logic                      out_bad_opcode,
  output logic                      out_halted,
  output logic signed [WORD_W-1:0]  out_first_register
);

  // Handshake
  logic in_accept;
  logic exec;

  // Input register
  logic       s1_vld_r;
  logic [7:0] s1_op_r;
  logic [7:0] s1_a_r;

  // Data memory and read path
  word_t              mem [MEM_WORDS];
  logic [MEM_WORDS-1:0] mem_vld_r;
  logic [MEM_AW-1:0]  rd_addr;
  word_t              rd_raw_r;
  logic               rd_vld_r;
  logic               rd_fwd_r;
  word_t              rd_fwd_data_r;
  word_t              mem_rdata;

  // Architectural state
  word_t              r_r     [NUM_REGS];
  word_t              r_nxt   [NUM_REGS];
  logic               zf_r, zf_nxt;
  logic               cf_r, cf_nxt;
  logic [PC_W-1:0]    pc_r, pc_nxt;
  logic [COLOR_W-1:0] col_r [3];

  // Execute results
  logic               mem_we;
  logic [MEM_AW-1:0]  mem_waddr;
  word_t              mem_wdata;
  logic [2*WORD_W-1:0] mul_full;
  word_t              alu_res;
  logic               halt;
  logic               bad;
  logic               pw;
  logic [7:0]         slot;
  logic [7:0]         px;
  logic [7:0]         py;
  logic [COLOR_W-1:0] cr, cg, cb;

  // Output register
  logic               o_vld_r;
  logic [PC_W-1:0]    o_pc_r;
  logic               o_pw_r;
  logic [7:0]         o_slot_r;
  logic [7:0]         o_px_r;
  logic [7:0]         o_py_r;
  logic [COLOR_W-1:0] o_cr_r, o_cg_r, o_cb_r;
  logic               o_bad_r;
  logic               o_halt_r;
  word_t              o_r1_r;

  // Execute when the result register is free or being drained
  assign exec      = s1_vld_r && (!o_vld_r || !out_stall);
  assign in_stall  = s1_vld_r && !exec;
  assign in_accept = in_valid && !in_stall;

  // Select the memory address of the incoming instruction
  assign rd_addr = (in_opcode == OP_MEMMOV) ? in_operand_b : in_operand_a;

  // Input register: advance on accept, drop after execute
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (in_accept) begin
      s1_vld_r <= 1'b1;
    end else if (exec) begin
      s1_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_op_r <= in_opcode;
      s1_a_r  <= in_operand_a;
    end
  end

  // Data memory: write from execute, registered read at accept
  always_ff @(posedge clk) begin
    if (exec && mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (in_accept) begin
      rd_raw_r <= mem[rd_addr];
    end
  end

  // Word valid bits; an unwritten word reads as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mem_vld_r <= '0;
    end else if (exec && mem_we) begin
      mem_vld_r[mem_waddr] <= 1'b1;
    end
  end

  // Capture valid bit and forward a same-edge write to the read address
  always_ff @(posedge clk) begin
    if (in_accept) begin
      rd_vld_r      <= mem_vld_r[rd_addr];
      rd_fwd_r      <= exec && mem_we && (mem_waddr == rd_addr);
      rd_fwd_data_r <= mem_wdata;
    end
  end

  assign mem_rdata = rd_fwd_r ? rd_fwd_data_r : (rd_vld_r ? rd_raw_r : '0);

  // Arithmetic on register one and two
  assign mul_full = {{WORD_W{1'b0}}, r_r[0]} * {{WORD_W{1'b0}}, r_r[1]};

  always_comb begin
    unique case (s1_op_r)
      OP_ADD:  alu_res = r_r[0] + r_r[1];
      OP_SUB:  alu_res = r_r[0] - r_r[1];
      default: alu_res = mul_full[WORD_W-1:0];
    endcase
  end

  // Execute one instruction
  always_comb begin
    r_nxt     = r_r;
    zf_nxt    = zf_r;
    cf_nxt    = cf_r;
    pc_nxt    = pc_r;
    mem_we    = 1'b0;
    mem_waddr = s1_a_r;
    mem_wdata = r_r[0];
    halt      = 1'b0;
    bad       = 1'b0;
    pw        = 1'b0;
    slot      = '0;
    px        = '0;
    py        = '0;
    cr        = '0;
    cg        = '0;
    cb        = '0;
    if (pc_r >= PROGRAM_SIZE) begin
      halt = 1'b1;
    end else begin
      unique case (s1_op_r)
        OP_NOP: begin
          pc_nxt = pc_r + LEN_1;
        end
        OP_ADD, OP_SUB, OP_MUL: begin
          r_nxt[0] = alu_res;
          zf_nxt   = (alu_res == '0);
          pc_nxt   = pc_r + LEN_1;
        end
        OP_LDI_R1: begin
          r_nxt[0] = {8'd0, s1_a_r};
          pc_nxt   = pc_r + LEN_2;
        end
        OP_LDI_R2: begin
          r_nxt[1] = {8'd0, s1_a_r};
          pc_nxt   = pc_r + LEN_2;
        end
        OP_MOV: begin
          unique case (s1_a_r)
            MOV_R1_TO_R2: r_nxt[1] = r_r[0];
            MOV_R2_TO_R3: r_nxt[2] = r_r[1];
            MOV_R3_TO_R4: r_nxt[3] = r_r[2];
            MOV_R4_TO_R1: r_nxt[0] = r_r[3];
            default: ;
          endcase
          pc_nxt = pc_r + LEN_2;
        end
        OP_CMP: begin
          cf_nxt = (r_r[0] == r_r[1]);
          pc_nxt = pc_r + LEN_1;
        end
        OP_MEMMOV: begin
          mem_we    = 1'b1;
          mem_wdata = mem_rdata;
          pc_nxt    = pc_r + LEN_3;
        end
        OP_JEQ: begin
          pc_nxt = cf_r ? {3'd0, s1_a_r} : pc_r + LEN_2;
        end
        OP_JZ: begin
          pc_nxt = zf_r ? {3'd0, s1_a_r} : pc_r + LEN_2;
        end
        OP_JC, OP_JO: begin
          // No instruction sets carry or overflow: never taken
          pc_nxt = pc_r + LEN_2;
        end
        OP_PIXEL: begin
          pw     = 1'b1;
          slot   = s1_a_r;
          px     = r_r[0][7:0];
          py     = r_r[1][7:0];
          cr     = col_r[0];
          cg     = col_r[1];
          cb     = col_r[2];
          pc_nxt = pc_r + LEN_2;
        end
        OP_STORE: begin
          mem_we = 1'b1;
          pc_nxt = pc_r + LEN_2;
        end
        OP_LOAD: begin
          r_nxt[0] = mem_rdata;
          pc_nxt   = pc_r + LEN_2;
        end
        default: begin
          bad    = 1'b1;
          pc_nxt = pc_r + LEN_1;
        end
      endcase
    end
  end

  // Commit architectural state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_REGS; i++) begin
        r_r[i] <= '0;
      end
      zf_r <= 1'b0;
      cf_r <= 1'b0;
      pc_r <= '0;
    end else if (exec) begin
      r_r  <= r_nxt;
      zf_r <= zf_nxt;
      cf_r <= cf_nxt;
      pc_r <= pc_nxt;
    end
  end

  // Shadow the low bits of the colour words
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 3; i++) begin
        col_r[i] <= '0;
      end
    end else if (exec && mem_we) begin
      if (mem_waddr == ADDR_RED) begin
        col_r[0] <= mem_wdata[COLOR_W-1:0];
      end
      if (mem_waddr == ADDR_GREEN) begin
        col_r[1] <= mem_wdata[COLOR_W-1:0];
      end
      if (mem_waddr == ADDR_BLUE) begin
        col_r[2] <= mem_wdata[COLOR_W-1:0];
      end
    end
  end

  // Output register: load on execute, drop when taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_vld_r <= 1'b0;
    end else if (exec) begin
      o_vld_r <= 1'b1;
    end else if (!out_stall) begin
      o_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (exec) begin
      o_pc_r   <= pc_nxt;
      o_pw_r   <= pw;
      o_slot_r <= slot;
      o_px_r   <= px;
      o_py_r   <= py;
      o_cr_r   <= cr;
      o_cg_r   <= cg;
      o_cb_r   <= cb;
      o_bad_r  <= bad;
      o_halt_r <= halt;
      o_r1_r   <= r_nxt[0];
    end
  end

  assign out_valid          = o_vld_r;
  assign out_next_pc        = o_pc_r;
  assign out_pixel_write    = o_pw_r;
  assign out_pixel_slot     = o_slot_r;
  assign out_pixel_x        = o_px_r;
  assign out_pixel_y        = o_py_r;
  assign out_red            = o_cr_r;
  assign out_green          = o_cg_r;
  assign out_blue           = o_cb_r;
  assign out_bad_opcode     = o_bad_r;
  assign out_halted         = o_halt_r;
  assign out_first_register = $signed(o_r1_r);

  // Checks
  `TCIS_ASSERT_NOW(a_no_stall_when_empty, clk, rst_n, !s1_vld_r, !in_stall)
  `TCIS_ASSERT_NEXT(a_exec_fills_output, clk, rst_n, exec, o_vld_r)
  `TCIS_ASSERT_NOW(a_pc_in_range, clk, rst_n, 1'b1, pc_r <= PC_MAX)
  `TCIS_ASSERT_NOW(a_halt_is_quiet, clk, rst_n, out_valid && out_halted,
    !out_pixel_write && !out_bad_opcode && (out_next_pc >= PROGRAM_SIZE))
  `TCIS_ASSERT_NOW(a_no_pixel_zero_fields, clk, rst_n, out_valid && !out_pixel_write,
    (out_pixel_slot == '0) && (out_pixel_x == '0) && (out_red == '0) && (out_blue == '0))

endmodule

FILE: test/toy_cpu_instruction_step_top_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// toy_cpu_instruction_step_top_test
// Self-checking bench for the toy CPU step block. A program stream is built
// up front: directed opcode and corner coverage, then random instructions
// mixed with short sequences that take branches, paint pixels and shuffle data
// memory. Periodic jumps back keep the counter in range. A closing walk drives
// it past the program size into the halted state. A shadow CPU computes each
// step's result at the input handshake, and the output monitor checks every
// field in order.
// ----------------------------------------------------------------------------
module toy_cpu_instruction_step_top_test;
  import tcis_pkg::*;

  localparam int RANDOM_ITEMS = 1350;
  localparam int CALM_ITEMS   = 300;
  localparam int CYCLE_LIMIT  = 200000;

  localparam logic [7:0] SHORT_OPS [5] = '{OP_NOP, OP_ADD, OP_SUB, OP_MUL, OP_CMP};
  localparam logic [7:0] TWO_BYTE_OPS [8] = '{OP_LDI_R1, OP_LDI_R2, OP_MOV, OP_JC,
                                              OP_JO, OP_PIXEL, OP_STORE, OP_LOAD};

  typedef struct packed {
    logic [7:0] opcode;
    logic [7:0] operand_a;
    logic [7:0] operand_b;
  } instr_t;

  typedef struct packed {
    logic [PC_W-1:0]    next_pc;
    logic               pixel_write;
    logic [7:0]         pixel_slot;
    logic [7:0]         pixel_x;
    logic [7:0]         pixel_y;
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
    logic               bad_opcode;
    logic               halted;
    word_t              first_register;
  } step_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [7:0] in_opcode = '0;
  logic [7:0] in_operand_a = '0;
  logic [7:0] in_operand_b = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [PC_W-1:0] out_next_pc;
  logic out_pixel_write;
  logic [7:0] out_pixel_slot;
  logic [7:0] out_pixel_x;
  logic [7:0] out_pixel_y;
  logic [COLOR_W-1:0] out_red;
  logic [COLOR_W-1:0] out_green;
  logic [COLOR_W-1:0] out_blue;
  logic out_bad_opcode;
  logic out_halted;
  logic signed [WORD_W-1:0] out_first_register;

  // Shadow CPU state
  word_t           cpu_regs [NUM_REGS];
  word_t           cpu_mem [MEM_WORDS];
  logic            cpu_zero;
  logic            cpu_equal;
  logic [PC_W-1:0] cpu_pc;

  instr_t       program_stream [$];
  step_result_t cpu_outcomes [$];
  instr_t       cur_instr;
  int           est_pc;

  int  mismatch_n = 0;
  int  steps_checked = 0;
  int  pixel_n = 0;
  int  bad_n = 0;
  int  halted_n = 0;
  int  jumps_n = 0;
  int  cycle_n = 0;
  int  send_gap = 0;
  int  hold_left = 0;
  int  phase_left = 0;
  logic idle_phase = 1'b0;
  logic calm_tail = 1'b0;

  toy_cpu_instruction_step_top uut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_opcode          (in_opcode),
    .in_operand_a       (in_operand_a),
    .in_operand_b       (in_operand_b),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_next_pc        (out_next_pc),
    .out_pixel_write    (out_pixel_write),
    .out_pixel_slot     (out_pixel_slot),
    .out_pixel_x        (out_pixel_x),
    .out_pixel_y        (out_pixel_y),
    .out_red            (out_red),
    .out_green          (out_green),
    .out_blue           (out_blue),
    .out_bad_opcode     (out_bad_opcode),
    .out_halted         (out_halted),
    .out_first_register (out_first_register)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Execute one instruction on the shadow CPU and return its result
  function automatic step_result_t run_instruction(instr_t ins);
    step_result_t res;
    logic [PC_W-1:0] npc;
    res = '0;
    if (cpu_pc >= PROGRAM_SIZE) begin
      res.halted = 1'b1;
    end else begin
      npc = cpu_pc + LEN_2;
      case (ins.opcode)
        OP_NOP: npc = cpu_pc + LEN_1;
        OP_ADD, OP_SUB, OP_MUL: begin
          if (ins.opcode == OP_ADD) cpu_regs[0] = cpu_regs[0] + cpu_regs[1];
          else if (ins.opcode == OP_SUB) cpu_regs[0] = cpu_regs[0] - cpu_regs[1];
          else cpu_regs[0] = cpu_regs[0] * cpu_regs[1];
          cpu_zero = (cpu_regs[0] == '0);
          npc = cpu_pc + LEN_1;
        end
        OP_LDI_R1: cpu_regs[0] = word_t'(ins.operand_a);
        OP_LDI_R2: cpu_regs[1] = word_t'(ins.operand_a);
        OP_MOV: begin
          case (ins.operand_a)
            MOV_R1_TO_R2: cpu_regs[1] = cpu_regs[0];
            MOV_R2_TO_R3: cpu_regs[2] = cpu_regs[1];
            MOV_R3_TO_R4: cpu_regs[3] = cpu_regs[2];
            MOV_R4_TO_R1: cpu_regs[0] = cpu_regs[3];
            default: ;
          endcase
        end
        OP_CMP: begin
          cpu_equal = (cpu_regs[0] == cpu_regs[1]);
          npc = cpu_pc + LEN_1;
        end
        OP_MEMMOV: begin
          cpu_mem[ins.operand_a] = cpu_mem[ins.operand_b];
          npc = cpu_pc + LEN_3;
        end
        OP_JEQ, OP_JZ: begin
          if ((ins.opcode == OP_JEQ) ? cpu_equal : cpu_zero) begin
            npc = PC_W'(ins.operand_a);
            jumps_n++;
          end
        end
        OP_JC, OP_JO: ;
        OP_PIXEL: begin
          res.pixel_write = 1'b1;
          res.pixel_slot  = ins.operand_a;
          res.pixel_x     = cpu_regs[0][7:0];
          res.pixel_y     = cpu_regs[1][7:0];
          res.red         = cpu_mem[ADDR_RED][COLOR_W-1:0];
          res.green       = cpu_mem[ADDR_GREEN][COLOR_W-1:0];
          res.blue        = cpu_mem[ADDR_BLUE][COLOR_W-1:0];
        end
        OP_STORE: cpu_mem[ins.operand_a] = cpu_regs[0];
        OP_LOAD: cpu_regs[0] = cpu_mem[ins.operand_a];
        default: begin
          res.bad_opcode = 1'b1;
          npc = cpu_pc + LEN_1;
        end
      endcase
      cpu_pc = npc;
    end
    res.next_pc = cpu_pc;
    res.first_register = cpu_regs[0];
    return res;
  endfunction

  task automatic report_mismatch(string msg);
    $display("[%0d] MISMATCH %s", cycle_n, msg);
    mismatch_n++;
  endtask

  task automatic check_field(string name, logic [15:0] got, logic [15:0] want);
    if (got !== want)
      report_mismatch($sformatf("step %0d %s: got %h, want %h", steps_checked, name, got, want));
  endtask

  // Random byte for operands
  function automatic logic [7:0] rand_byte();
    return 8'($urandom);
  endfunction

  // Queue an instruction and keep an upper bound on the program counter
  task automatic add_instr(logic [7:0] op, logic [7:0] a, logic [7:0] b);
    instr_t ins;
    ins = '{opcode: op, operand_a: a, operand_b: b};
    program_stream.push_back(ins);
    case (op)
      OP_MEMMOV: est_pc += LEN_3;
      OP_JEQ, OP_JZ: est_pc = (int'(a) > est_pc + 2) ? int'(a) : est_pc + 2;
      OP_LDI_R1, OP_LDI_R2, OP_MOV, OP_JC, OP_JO, OP_PIXEL, OP_STORE, OP_LOAD:
        est_pc += LEN_2;
      default: est_pc += LEN_1;
    endcase
  endtask

  // Force a taken branch: equal registers, compare, jump
  task automatic rewind_program(logic [7:0] target);
    logic [7:0] v;
    v = rand_byte();
    add_instr(OP_LDI_R1, v, rand_byte());
    add_instr(OP_LDI_R2, v, rand_byte());
    add_instr(OP_CMP, rand_byte(), rand_byte());
    add_instr(OP_JEQ, target, rand_byte());
    est_pc = target;
  endtask

  // Favor low addresses so stores, loads and colour words meet often
  function automatic logic [7:0] pick_byte();
    return ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 7)) : 8'($urandom);
  endfunction

  // Build the program stream, reset, then wait for the pipeline to drain
  initial begin
    int kind;
    int room;
    int len;
    logic [7:0] v;
    logic [7:0] w;

    foreach (cpu_regs[i]) cpu_regs[i] = '0;
    foreach (cpu_mem[i]) cpu_mem[i] = '0;
    cpu_zero = 1'b0;
    cpu_equal = 1'b0;
    cpu_pc = '0;
    est_pc = 0;

    // directed: operand extremes, every opcode, zero and equal branches taken
    add_instr(OP_NOP, 8'hFF, 8'hFF);
    add_instr(OP_LDI_R1, 8'hFF, 8'h00);
    add_instr(OP_LDI_R2, 8'hFF, 8'h00);
    add_instr(OP_MUL, 8'h00, 8'h00);
    add_instr(OP_MUL, 8'hFF, 8'hFF);
    add_instr(OP_ADD, 8'h00, 8'h00);
    add_instr(OP_SUB, 8'h00, 8'h00);
    add_instr(OP_MOV, MOV_R1_TO_R2, 8'h00);
    add_instr(OP_SUB, 8'h00, 8'h00);
    add_instr(OP_JZ, 8'h10, 8'h00);
    add_instr(OP_MOV, MOV_R2_TO_R3, 8'h00);
    add_instr(OP_MOV, MOV_R3_TO_R4, 8'h00);
    add_instr(OP_MOV, MOV_R4_TO_R1, 8'h00);
    add_instr(OP_MOV, 8'hFF, 8'h00);
    add_instr(OP_CMP, 8'h00, 8'h00);
    add_instr(OP_JEQ, 8'h00, 8'h00);
    add_instr(OP_STORE, ADDR_RED, 8'h00);
    add_instr(OP_STORE, 8'hFF, 8'h00);
    add_instr(OP_MEMMOV, ADDR_GREEN, ADDR_RED);
    add_instr(OP_MEMMOV, ADDR_BLUE, 8'hFF);
    add_instr(OP_PIXEL, 8'hFF, 8'h00);
    add_instr(OP_LOAD, 8'hFF, 8'h00);
    add_instr(OP_JC, 8'hAB, 8'h55);
    add_instr(OP_JO, 8'h55, 8'hAB);
    add_instr(8'h10, 8'h00, 8'h00);
    add_instr(8'hFF, 8'hFF, 8'hFF);

    // random instructions and well-formed sequences
    while (program_stream.size() < RANDOM_ITEMS + 26) begin
      if (est_pc > 990) rewind_program(rand_byte());
      kind = $urandom_range(0, 99);
      v = rand_byte();
      if (kind < 55) begin
        add_instr(8'($urandom_range(OP_NOP, OP_LOAD)), pick_byte(), pick_byte());
      end else if (kind < 63) begin
        add_instr(8'($urandom_range(OP_LOAD + 1, 255)), rand_byte(), rand_byte());
      end else if (kind < 73) begin
        add_instr(OP_LDI_R1, v, rand_byte());
        add_instr(OP_LDI_R2, ($urandom_range(0, 3) == 0) ? rand_byte() : v, rand_byte());
        add_instr(OP_SUB, rand_byte(), rand_byte());
        add_instr(OP_JZ, rand_byte(), rand_byte());
      end else if (kind < 83) begin
        w = ($urandom_range(0, 1) == 0) ? v : rand_byte();
        add_instr(OP_LDI_R1, v, rand_byte());
        add_instr(OP_LDI_R2, w, rand_byte());
        add_instr(OP_CMP, rand_byte(), rand_byte());
        add_instr(OP_JEQ, rand_byte(), rand_byte());
      end else if (kind < 93) begin
        add_instr(OP_LDI_R1, v, rand_byte());
        add_instr(OP_STORE, 8'($urandom_range(ADDR_RED, ADDR_BLUE)), rand_byte());
        add_instr(OP_LDI_R2, rand_byte(), rand_byte());
        add_instr(OP_PIXEL, rand_byte(), rand_byte());
      end else begin
        add_instr(OP_LDI_R1, v, rand_byte());
        add_instr(OP_MUL, rand_byte(), rand_byte());
        add_instr(OP_STORE, pick_byte(), rand_byte());
        add_instr(OP_MEMMOV, pick_byte(), pick_byte());
        add_instr(OP_LOAD, pick_byte(), rand_byte());
      end
    end

    // walk from a known counter right up to the program size, then past it
    if (est_pc > 990) rewind_program(rand_byte());
    rewind_program(8'hFF);
    while (est_pc < PROGRAM_SIZE - 1) begin
      room = PROGRAM_SIZE - 1 - est_pc;
      len = $urandom_range(1, (room < 3) ? room : 3);
      if (len == 1) add_instr(SHORT_OPS[$urandom_range(0, 4)], pick_byte(), pick_byte());
      else if (len == 2) add_instr(TWO_BYTE_OPS[$urandom_range(0, 7)], pick_byte(), pick_byte());
      else add_instr(OP_MEMMOV, pick_byte(), pick_byte());
    end
    add_instr(OP_MEMMOV, pick_byte(), pick_byte());
    repeat (8) add_instr(rand_byte(), rand_byte(), rand_byte());

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    while (program_stream.size() != 0 || in_valid) @(posedge clk);
    while (cpu_outcomes.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("Ran %0d steps: %0d pixel stores, %0d bad opcodes, %0d taken jumps, %0d halted.",
             steps_checked, pixel_n, bad_n, jumps_n, halted_n);
    $display("%0d field mismatches over %0d cycles.", mismatch_n, cycle_n);
    if (mismatch_n == 0) begin
      $display("toy_cpu_instruction_step_top verification clean");
    end else begin
      $display("toy_cpu_instruction_step_top verification failed");
    end
    $finish;
  end

  // Cycle count, timeout and the idle/busy phases shared by both sides
  always @(posedge clk) begin
    cycle_n++;
    if (cycle_n >= CYCLE_LIMIT) begin
      $display("Timeout at cycle %0d, %0d results outstanding", cycle_n, cpu_outcomes.size());
      $display("toy_cpu_instruction_step_top verification failed");
      $finish;
    end
    if (phase_left == 0) begin
      idle_phase <= ($urandom_range(0, 2) != 0);
      phase_left <= $urandom_range(20, 150);
    end else begin
      phase_left <= phase_left - 1;
    end
  end

  // Driver: present pending instructions, predict each transaction on accept
  always @(posedge clk) begin : drive_proc
    logic load_next;
    if (!rst_n) begin
      in_valid     <= 1'b0;
      in_opcode    <= '0;
      in_operand_a <= '0;
      in_operand_b <= '0;
    end else begin
      load_next = !in_valid;
      if (in_valid && !in_stall) begin
        cpu_outcomes.push_back(run_instruction(cur_instr));
        load_next = 1'b1;
        if (!calm_tail && idle_phase && $urandom_range(0, 3) == 0)
          send_gap = $urandom_range(1, 9);
      end
      if (load_next) begin
        if (send_gap > 0 || program_stream.size() == 0) begin
          if (send_gap > 0) send_gap--;
          in_valid <= 1'b0;
        end else begin
          cur_instr = program_stream.pop_front();
          in_valid     <= 1'b1;
          in_opcode    <= cur_instr.opcode;
          in_operand_a <= cur_instr.operand_a;
          in_operand_b <= cur_instr.operand_b;
        end
      end
      calm_tail <= (program_stream.size() < CALM_ITEMS);
    end
  end

  // Monitor: check each accepted result against the oldest prediction
  always @(posedge clk) begin : watch_proc
    step_result_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (cpu_outcomes.size() == 0) begin
          report_mismatch($sformatf("result with nothing pending, next_pc %h", out_next_pc));
        end else begin
          want = cpu_outcomes.pop_front();
          check_field("next_pc", 16'(out_next_pc), 16'(want.next_pc));
          check_field("pixel_write", 16'(out_pixel_write), 16'(want.pixel_write));
          check_field("pixel_slot", 16'(out_pixel_slot), 16'(want.pixel_slot));
          check_field("pixel_x", 16'(out_pixel_x), 16'(want.pixel_x));
          check_field("pixel_y", 16'(out_pixel_y), 16'(want.pixel_y));
          check_field("red", 16'(out_red), 16'(want.red));
          check_field("green", 16'(out_green), 16'(want.green));
          check_field("blue", 16'(out_blue), 16'(want.blue));
          check_field("bad_opcode", 16'(out_bad_opcode), 16'(want.bad_opcode));
          check_field("halted", 16'(out_halted), 16'(want.halted));
          check_field("first_register", 16'(out_first_register), want.first_register);
          pixel_n  += int'(want.pixel_write);
          bad_n    += int'(want.bad_opcode);
          halted_n += int'(want.halted);
        end
        steps_checked++;
      end
      // hold off the result channel in random bursts
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (!calm_tail && idle_phase && $urandom_range(0, 5) == 0) begin
        hold_left = $urandom_range(0, 8);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

endmodule

FILE: toy_cpu_instruction_step_top.f
+incdir+design
design/tcis_pkg.sv
design/toy_cpu_instruction_step_top.sv
test/toy_cpu_instruction_step_top_test.sv
